### hdl/lddf_pkg.sv
package lddf_pkg;

    localparam int POS_BITS = 12;
    localparam int CNT_W    = POS_BITS + 1;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 13;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CAP_LIMIT = 1 << POS_BITS;
    localparam int HIGH_W   = 3;

    localparam logic [BYTE_W-1:0] FLAG_BYTE      = 8'h7E;
    localparam logic [HIGH_W-1:0] HIGH_BITS_MASK = 3'h7;
    localparam logic [CFG_W-1:0]  MAX_LEN_RESET  = 13'd2048;

    localparam int PAYLOAD_W = BYTE_W + POS_BITS + CNT_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - PAYLOAD_W;

    localparam int TUSER_W     = 3;
    localparam int USER_VALID  = 0;
    localparam int USER_DONE   = 1;
    localparam int USER_OVF    = 2;

endpackage

### hdl/length_delimited_flag_deframer.sv
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_tready is high; the single output register
// frees itself in the same cycle that its result is taken, so a byte may be accepted.
// Reset (aresetn low at a clock edge) returns the block to hunting for a flag,
// clears the body count and format bytes, sets the capacity to 2048 and drops
// any pending result.
module length_delimited_flag_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lddf_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lddf_pkg::BYTE_W-1:0]  s_tdata,   // in_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lddf_pkg::TDATA_W-1:0] m_tdata,   // data_byte, byte_pos, frame_len
    output logic [lddf_pkg::TUSER_W-1:0] m_tuser    // byte_valid, frame_done, overflow
);
    import lddf_pkg::*;

    logic [CFG_W-1:0]    max_len_reg;
    logic                in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]    body_count_reg, body_count_next;
    logic [HIGH_W-1:0]   fmt_high_reg, fmt_high_next;
    logic [BYTE_W-1:0]   fmt_low_reg, fmt_low_next;

    logic                m_tvalid_reg;
    logic [BYTE_W-1:0]   data_byte_reg, data_byte_next;
    logic [POS_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [CNT_W-1:0]    frame_len_reg, frame_len_next;
    logic                byte_valid_reg, byte_valid_next;
    logic                frame_done_reg, frame_done_next;
    logic                overflow_reg, overflow_next;

    logic                s_accept;
    logic                is_flag;
    logic                closes;
    logic [CMP_W-1:0]    max_len_ext;
    logic [CMP_W-1:0]    eff_cap;
    logic [HIGH_W+BYTE_W-1:0] expected_len;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_flag  = (s_tdata == FLAG_BYTE);
    assign expected_len = {fmt_high_reg, fmt_low_reg};
    assign max_len_ext  = CMP_W'(max_len_reg);
    assign eff_cap      = (max_len_ext > CMP_W'(CAP_LIMIT)) ? CMP_W'(CAP_LIMIT) : max_len_ext;

    always_comb begin
        in_frame_next   = in_frame_reg;
        body_count_next = body_count_reg;
        fmt_high_next   = fmt_high_reg;
        fmt_low_next    = fmt_low_reg;
        byte_valid_next = 1'b0;
        data_byte_next  = '0;
        byte_pos_next   = '0;
        frame_done_next = 1'b0;
        frame_len_next  = '0;
        overflow_next   = 1'b0;
        closes          = 1'b0;
        if (!in_frame_reg) begin
            if (is_flag) begin
                in_frame_next = 1'b1;
            end
        end else if (!(is_flag && body_count_reg == '0)) begin
            if (is_flag) begin
                if (body_count_reg <= CNT_W'(2)) begin
                    closes = 1'b1;
                end else if (body_count_reg >= CNT_W'(expected_len)) begin
                    closes = 1'b1;
                end
            end
            if (closes) begin
                frame_done_next = 1'b1;
                frame_len_next  = body_count_reg;
                body_count_next = '0;
            end else if (CMP_W'(body_count_reg) >= eff_cap) begin
                overflow_next   = 1'b1;
                in_frame_next   = 1'b0;
                body_count_next = '0;
            end else begin
                if (body_count_reg == '0) begin
                    fmt_high_next = s_tdata[HIGH_W-1:0] & HIGH_BITS_MASK;
                end else if (body_count_reg == CNT_W'(1)) begin
                    fmt_low_next = s_tdata;
                end
                byte_valid_next = 1'b1;
                data_byte_next  = s_tdata;
                byte_pos_next   = body_count_reg[POS_BITS-1:0];
                body_count_next = body_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            in_frame_reg   <= 1'b0;
            body_count_reg <= '0;
            fmt_high_reg   <= '0;
            fmt_low_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (s_accept) begin
                in_frame_reg   <= in_frame_next;
                body_count_reg <= body_count_next;
                fmt_high_reg   <= fmt_high_next;
                fmt_low_reg    <= fmt_low_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_valid_reg <= byte_valid_next;
            data_byte_reg  <= data_byte_next;
            byte_pos_reg   <= byte_pos_next;
            frame_done_reg <= frame_done_next;
            frame_len_reg  <= frame_len_next;
            overflow_reg   <= overflow_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, frame_len_reg, byte_pos_reg, data_byte_reg};
    always_comb begin
        m_tuser             = '0;
        m_tuser[USER_VALID] = byte_valid_reg;
        m_tuser[USER_DONE]  = frame_done_reg;
        m_tuser[USER_OVF]   = overflow_reg;
    end

    // The body count can never pass the largest capacity.
    assert_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        body_count_reg <= CNT_W'(CAP_LIMIT))
        else $error("body count beyond capacity limit");

    // An overflow request returns the block to hunting with a cleared count.
    assert_ovf_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && overflow_next |=> !in_frame_reg && body_count_reg == '0)
        else $error("overflow did not return to hunting");

    // A closing flag keeps the block in a frame and restarts the count.
    assert_done_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && frame_done_next |=> in_frame_reg && body_count_reg == '0)
        else $error("closing flag did not open the next frame");

    // A result carries at most one of body byte, frame end and overflow.
    assert_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $onehot0({byte_valid_reg, frame_done_reg, overflow_reg}))
        else $error("result marks more than one kind");

    // A stored body byte advances the count by exactly one.
    assert_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && byte_valid_next |=>
            body_count_reg == $past(body_count_reg) + CNT_W'(1))
        else $error("body count did not advance");

endmodule
